// ===== design/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sonar speed display package
// Shared widths, codes, lookup tables and interface types for the sonar
// speed meter and its multiplexed seven-segment display.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Window length and derived widths
  localparam int SAMPLES = 10;
  localparam int CNT_W   = $clog2(SAMPLES + 1);
  localparam int DIST_W  = 12;
  localparam int WORD_W  = 16;
  localparam int TERM_W  = 13;
  localparam int PROD_W  = 2 * WORD_W;

  // Saturation and display limits
  localparam logic [WORD_W-1:0] SUM_MAX  = 16'hFFFF;
  localparam logic [WORD_W-1:0] SHOW_MAX = 16'd999;

  // Reciprocal constants for division by 3, 100 and 10
  localparam logic [15:0] DIV3_RECIP   = 16'd43691;
  localparam int          DIV3_SHIFT   = 17;
  localparam logic [5:0]  DIV100_RECIP = 6'd41;
  localparam int          DIV100_SHIFT = 12;
  localparam logic [7:0]  DIV10_RECIP  = 8'd205;
  localparam int          DIV10_SHIFT  = 11;
  localparam logic [6:0]  RADIX_HUND   = 7'd100;
  localparam logic [3:0]  RADIX_TEN    = 4'd10;

  // Drive for the hundreds digit; lower digits shift right from it
  localparam logic [2:0] DEN_HUND = 3'b100;

  // Register file port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Reset values of the configuration registers
  localparam logic [WORD_W-1:0] MIN_SPEED_RST      = 16'd10;
  localparam logic [WORD_W-1:0] DISPLAY_ROUNDS_RST = 16'd1000;
  localparam logic [WORD_W-1:0] SPEED_SCALE_RST    = 16'd15943;

  typedef enum logic [1:0] {
    REG_MIN_SPEED      = 2'd0,
    REG_DISPLAY_ROUNDS = 2'd1,
    REG_SPEED_SCALE    = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_t;

  typedef enum logic [2:0] {
    BK_RUN   = 3'd0,
    BK_FOLD  = 3'd1,
    BK_MUL   = 3'd2,
    BK_SPLIT = 3'd3,
    BK_EMIT  = 3'd4
  } back_state_t;

  // Active-low patterns for digits 0 through 9
  localparam logic [7:0] SEG_TABLE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  typedef struct packed {
    item_kind_t        kind;
    logic [DIST_W-1:0] distance;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] min_speed;
    logic [WORD_W-1:0] display_rounds;
    logic [WORD_W-1:0] speed_scale;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        digit_enable;
    logic [7:0]        segments;
    logic [WORD_W-1:0] speed_value;
    logic              speed_valid;
    logic              sample_dropped;
  } result_t;

  // Segment pattern of one digit, all bits zero for codes above nine
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pat;
    pat = 8'h00;
    if (digit < RADIX_TEN) begin
      pat = SEG_TABLE[digit];
    end
    return pat;
  endfunction

endpackage

// ===== design/sonar_speed_seven_segment_display.sv =====
// ----------------------------------------------------------------------------
// Sonar speed seven-segment display
// Windowed centered-difference speed meter with a three-digit multiplexed
// active-low seven-segment drive and an APB register file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per item: opcode 0
//   is a distance sample in cm, opcode 1 is one multiplex tick. Every request
//   yields exactly one result on the output channel (out_valid/out_ready).
//   Registers min_speed, display_rounds and speed_scale sit at byte
//   addresses 0, 4 and 8; write them only while the block is idle.
//   Ticks and ordinary samples pass through the request queue and the output
//   register. The sample that closes a window also passes the states FOLD,
//   MUL, SPLIT and EMIT: the back end folds the last term, multiplies by
//   speed_scale, splits the digits and emits, holding the queue meanwhile.
//   Throughput is one request per cycle while the receiver keeps up, apart
//   from the closure once per window of SAMPLES samples; under steady traffic
//   the two-entry request queue then fills and in_ready stays low.
//   A stalled receiver holds the result in the output register; the back
//   end then stops draining the queue and in_ready drops once it is full.
//   Synchronous reset clears the window, turns the display off and restores
//   the register defaults (10, 1000, 15943). No clearing pass is needed.
// ----------------------------------------------------------------------------
module sonar_speed_seven_segment_display (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [ssd_pkg::DIST_W-1:0]  in_distance,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_digit_enable,
  output logic [7:0]                  out_segments,
  output logic [ssd_pkg::WORD_W-1:0]  out_speed_value,
  output logic                        out_speed_valid,
  output logic                        out_sample_dropped,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssd_pkg::APB_AW-1:0]  paddr,
  input  logic [ssd_pkg::APB_DW-1:0]  pwdata,
  output logic [ssd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int WW = ssd_pkg::WORD_W;

  logic [WW-1:0]    min_speed_r;
  logic [WW-1:0]    display_rounds_r;
  logic [WW-1:0]    speed_scale_r;
  logic             reg_wr;
  logic [1:0]       reg_idx;
  logic [WW-1:0]    reg_rd;
  ssd_pkg::cfg_t    cfg;
  logic             q_valid;
  logic             q_ready;
  ssd_pkg::item_t   q_item;
  ssd_pkg::result_t res;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r      <= ssd_pkg::MIN_SPEED_RST;
      display_rounds_r <= ssd_pkg::DISPLAY_ROUNDS_RST;
      speed_scale_r    <= ssd_pkg::SPEED_SCALE_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        ssd_pkg::REG_MIN_SPEED:      min_speed_r      <= pwdata[WW-1:0];
        ssd_pkg::REG_DISPLAY_ROUNDS: display_rounds_r <= pwdata[WW-1:0];
        ssd_pkg::REG_SPEED_SCALE:    speed_scale_r    <= pwdata[WW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      ssd_pkg::REG_MIN_SPEED:      reg_rd = min_speed_r;
      ssd_pkg::REG_DISPLAY_ROUNDS: reg_rd = display_rounds_r;
      ssd_pkg::REG_SPEED_SCALE:    reg_rd = speed_scale_r;
      default:                     reg_rd = '0;
    endcase
    prdata = ssd_pkg::APB_DW'(reg_rd);
  end

  always_comb begin
    cfg.min_speed      = min_speed_r;
    cfg.display_rounds = display_rounds_r;
    cfg.speed_scale    = speed_scale_r;
  end

  ssd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_distance (in_distance),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item)
  );

  ssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_digit_enable   = res.digit_enable;
  assign out_segments       = res.segments;
  assign out_speed_value    = res.speed_value;
  assign out_speed_valid    = res.speed_valid;
  assign out_sample_dropped = res.sample_dropped;

  // At most one digit is driven per result
  a_one_digit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_digit_enable))
    else $error("more than one digit driven");

  // Segments stay dark when no digit is driven
  a_dark_when_off : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_digit_enable == 3'b000) |-> (out_segments == 8'h00))
    else $error("segments lit with no digit enabled");

  // A closed window and a dropped sample never share a result
  a_drop_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_speed_valid && out_sample_dropped))
    else $error("speed and drop flagged together");

  // A result that carries a speed drives no digit
  a_speed_no_digit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_speed_valid) |-> (out_digit_enable == 3'b000))
    else $error("digit driven with a window result");

endmodule

// ===== design/ssd_front.sv =====
// ----------------------------------------------------------------------------
// Sonar speed display front end
// Takes requests from the input channel, classifies them as distance samples
// or multiplex ticks and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [ssd_pkg::DIST_W-1:0]  in_distance,
  output logic                        q_valid,
  input  logic                        q_ready,
  output ssd_pkg::item_t              q_item
);

  ssd_pkg::item_t entry_r [2];
  ssd_pkg::item_t new_item;
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     fill_r;
  logic [1:0]     fill_nxt;
  logic           push;
  logic           pop;

  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Classify the incoming request
  always_comb begin
    new_item.distance = in_distance;
    new_item.kind     = (in_opcode == ssd_pkg::OP_TICK) ? ssd_pkg::KIND_TICK
                                                        : ssd_pkg::KIND_SAMPLE;
  end

  // Track queue occupancy
  always_comb begin
    fill_nxt = fill_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  // Store queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== design/ssd_back.sv =====
// ----------------------------------------------------------------------------
// Sonar speed display back end
// Executes queued requests in order: accumulates difference terms, closes
// windows through a multiply and digit split sequence, and drives the
// multiplexed digits. Results leave through a registered output stage.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ssd_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  ssd_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output ssd_pkg::result_t out_res
);

  localparam int CW = ssd_pkg::CNT_W;
  localparam int DW = ssd_pkg::DIST_W;
  localparam int WW = ssd_pkg::WORD_W;
  localparam int TW = ssd_pkg::TERM_W;
  localparam int PW = ssd_pkg::PROD_W;

  ssd_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DW-1:0]        p1_r, p1_nxt;
  logic [DW-1:0]        p2_r, p2_nxt;
  logic [TW-1:0]        term_r, term_nxt;
  logic                 term_vld_r, term_vld_nxt;
  logic [WW-1:0]        sum_r, sum_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [WW-1:0]        speed_r, speed_nxt;
  logic [3:0]           hund_r, hund_nxt;
  logic [6:0]           rem_r, rem_nxt;
  logic                 disp_r, disp_nxt;
  logic [WW-1:0]        round_r, round_nxt;
  logic [1:0]           slot_r, slot_nxt;
  logic [11:0]          digits_r, digits_nxt;
  logic                 out_vld_r, out_vld_nxt;
  ssd_pkg::result_t     out_res_r, out_res_nxt;

  logic             out_free;
  logic             pop;
  logic             is_sample;
  logic [CW-1:0]    cnt_inc;
  logic             close_win;
  logic             emit;
  ssd_pkg::result_t emit_res;

  // Difference term datapath
  logic [DW-1:0]  diff;
  logic [14:0]    diff_x5;
  logic [30:0]    div3_prod;
  logic [TW-1:0]  term_c;
  logic [WW:0]    sum_add;
  logic [WW-1:0]  sum_fold;

  // Digit split datapath
  logic [15:0]    hund_prod;
  logic [3:0]     hund_c;
  logic [10:0]    hund_x;
  logic [9:0]     rem_wide;
  logic [14:0]    ten_prod;
  logic [3:0]     ten_c;
  logic [7:0]     ten_x;
  logic [6:0]     one_wide;
  logic           show;

  // Multiplex datapath
  logic [1:0]     slot_eff;
  logic [3:0]     digit_cur;
  logic [WW-1:0]  round_inc;
  logic           rounds_done;

  assign out_free  = !out_vld_r || out_ready;
  assign q_ready   = (state_r == ssd_pkg::BK_RUN) && out_free;
  assign pop       = q_valid && q_ready;
  assign is_sample = (q_item.kind == ssd_pkg::KIND_SAMPLE);
  assign cnt_inc   = cnt_r + CW'(1);
  assign close_win = is_sample && !disp_r && (cnt_inc >= CW'(ssd_pkg::SAMPLES));
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  // Term floor(|d - p2| * 5 / 3) and saturating fold into the sum
  always_comb begin
    diff      = (q_item.distance >= p2_r) ? (q_item.distance - p2_r)
                                          : (p2_r - q_item.distance);
    diff_x5   = {1'b0, diff, 2'b00} + {3'b000, diff};
    div3_prod = diff_x5 * ssd_pkg::DIV3_RECIP;
    term_c    = div3_prod[ssd_pkg::DIV3_SHIFT +: TW];
    sum_add   = {1'b0, sum_r} + (WW + 1)'(term_r);
    sum_fold  = sum_add[WW] ? ssd_pkg::SUM_MAX : sum_add[WW-1:0];
  end

  // Split speed into hundreds, tens and ones
  always_comb begin
    hund_prod = 16'(prod_r[WW +: 10] * ssd_pkg::DIV100_RECIP);
    hund_c    = hund_prod[ssd_pkg::DIV100_SHIFT +: 4];
    hund_x    = 11'(hund_c * ssd_pkg::RADIX_HUND);
    rem_wide  = prod_r[WW +: 10] - hund_x[9:0];
    ten_prod  = 15'(rem_r * ssd_pkg::DIV10_RECIP);
    ten_c     = ten_prod[ssd_pkg::DIV10_SHIFT +: 4];
    ten_x     = 8'(ten_c * ssd_pkg::RADIX_TEN);
    one_wide  = rem_r - ten_x[6:0];
    show      = (speed_r > cfg.min_speed) && (speed_r <= ssd_pkg::SHOW_MAX);
  end

  // Select the digit for the current multiplex slot
  always_comb begin
    slot_eff = (slot_r == 2'd3) ? 2'd0 : slot_r;
    case (slot_eff)
      2'd0:    digit_cur = digits_r[11:8];
      2'd1:    digit_cur = digits_r[7:4];
      default: digit_cur = digits_r[3:0];
    endcase
    round_inc   = round_r + WW'(1);
    rounds_done = (round_inc >= cfg.display_rounds) || (round_inc == '0);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssd_pkg::BK_RUN: begin
        if (pop && close_win) begin
          state_nxt = ssd_pkg::BK_FOLD;
        end
      end
      ssd_pkg::BK_FOLD:  state_nxt = ssd_pkg::BK_MUL;
      ssd_pkg::BK_MUL:   state_nxt = ssd_pkg::BK_SPLIT;
      ssd_pkg::BK_SPLIT: state_nxt = ssd_pkg::BK_EMIT;
      ssd_pkg::BK_EMIT: begin
        if (out_free) begin
          state_nxt = ssd_pkg::BK_RUN;
        end
      end
      default: state_nxt = ssd_pkg::BK_RUN;
    endcase
  end

  // Datapath updates and results
  always_comb begin
    cnt_nxt      = cnt_r;
    p1_nxt       = p1_r;
    p2_nxt       = p2_r;
    term_nxt     = term_r;
    term_vld_nxt = 1'b0;
    sum_nxt      = term_vld_r ? sum_fold : sum_r;
    prod_nxt     = prod_r;
    speed_nxt    = speed_r;
    hund_nxt     = hund_r;
    rem_nxt      = rem_r;
    disp_nxt     = disp_r;
    round_nxt    = round_r;
    slot_nxt     = slot_r;
    digits_nxt   = digits_r;
    emit         = 1'b0;
    emit_res     = '0;
    case (state_r)
      ssd_pkg::BK_RUN: begin
        if (pop) begin
          emit = !close_win;
          if (is_sample) begin
            if (disp_r) begin
              emit_res.sample_dropped = 1'b1;
            end else begin
              p1_nxt = q_item.distance;
              p2_nxt = p1_r;
              if (cnt_r >= CW'(2)) begin
                term_nxt     = term_c;
                term_vld_nxt = 1'b1;
              end
              cnt_nxt = close_win ? '0 : cnt_inc;
            end
          end else if (disp_r) begin
            emit_res.digit_enable = ssd_pkg::DEN_HUND >> slot_eff;
            emit_res.segments     = ssd_pkg::seg_of(digit_cur);
            if (slot_eff == 2'd2) begin
              slot_nxt  = 2'd0;
              round_nxt = round_inc;
              if (rounds_done) begin
                disp_nxt  = 1'b0;
                round_nxt = '0;
              end
            end else begin
              slot_nxt = slot_eff + 2'd1;
            end
          end
        end
      end
      ssd_pkg::BK_MUL: begin
        prod_nxt = sum_r * cfg.speed_scale;
        sum_nxt  = '0;
      end
      ssd_pkg::BK_SPLIT: begin
        speed_nxt = prod_r[PW-1:WW];
        hund_nxt  = hund_c;
        rem_nxt   = rem_wide[6:0];
      end
      ssd_pkg::BK_EMIT: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_res.speed_value = speed_r;
          emit_res.speed_valid = 1'b1;
          if (show) begin
            digits_nxt = {hund_r, ten_c, one_wide[3:0]};
            disp_nxt   = 1'b1;
            round_nxt  = '0;
            slot_nxt   = 2'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Load the output stage
  always_comb begin
    out_vld_nxt = out_vld_r && !out_ready;
    out_res_nxt = out_res_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = emit_res;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    term_r    <= term_nxt;
    prod_r    <= prod_nxt;
    speed_r   <= speed_nxt;
    hund_r    <= hund_nxt;
    rem_r     <= rem_nxt;
    out_res_r <= out_res_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ssd_pkg::BK_RUN;
      cnt_r      <= '0;
      term_vld_r <= 1'b0;
      sum_r      <= '0;
      disp_r     <= 1'b0;
      round_r    <= '0;
      slot_r     <= 2'd0;
      digits_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      term_vld_r <= term_vld_nxt;
      sum_r      <= sum_nxt;
      disp_r     <= disp_nxt;
      round_r    <= round_nxt;
      slot_r     <= slot_nxt;
      digits_r   <= digits_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

endmodule

// ===== test/sonar_speed_seven_segment_display_tb.sv =====
// ----------------------------------------------------------------------------
// Sonar speed seven-segment display testbench
// Drives distance samples and multiplex ticks through the request channel.
// A local predictor of the speed window and the digit multiplexer forms the
// expected result of every accepted request. Each returned result is checked
// field by field, in order. Phases vary the register settings, the sender
// gaps and the receiver stalls, and one phase holds the receiver off long
// enough to back up the request queue.
// ----------------------------------------------------------------------------
module sonar_speed_seven_segment_display_tb;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_opcode = ssd_pkg::OP_SAMPLE;
  logic [ssd_pkg::DIST_W-1:0]   in_distance = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [2:0]                   out_digit_enable;
  logic [7:0]                   out_segments;
  logic [ssd_pkg::WORD_W-1:0]   out_speed_value;
  logic                         out_speed_valid;
  logic                         out_sample_dropped;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [ssd_pkg::APB_AW-1:0]   paddr = '0;
  logic [ssd_pkg::APB_DW-1:0]   pwdata = '0;
  logic [ssd_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  // Predictor state: window, display and register copies
  logic [ssd_pkg::DIST_W-1:0]   win_store [ssd_pkg::SAMPLES];
  int unsigned                  win_count;
  int unsigned                  sum_acc;
  bit                           show_on;
  int unsigned                  rounds_shown;
  int unsigned                  slot_next;
  logic [11:0]                  shown_bcd;
  int unsigned                  min_reg;
  int unsigned                  rounds_reg;
  int unsigned                  scale_reg;

  // Distance ramp for well-formed random windows
  int                           ramp_base;
  int                           ramp_step;
  bit                           ramp_wild;

  ssd_pkg::result_t             pending_results [$];
  ssd_pkg::result_t             seen_result;
  ssd_pkg::result_t             want_result;
  int unsigned                  mismatch_count = 0;
  int                           send_idle_pct = 0;
  int                           recv_stall_pct = 0;
  int                           hold_left = 0;

  sonar_speed_seven_segment_display dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_distance        (in_distance),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digit_enable   (out_digit_enable),
    .out_segments       (out_segments),
    .out_speed_value    (out_speed_value),
    .out_speed_valid    (out_speed_valid),
    .out_sample_dropped (out_sample_dropped),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Active-low segment drive of one decimal digit
  function automatic logic [7:0] segment_pattern(input logic [3:0] digit);
    case (digit)
      4'd0: return 8'hC0;
      4'd1: return 8'hF9;
      4'd2: return 8'hA4;
      4'd3: return 8'hB0;
      4'd4: return 8'h99;
      4'd5: return 8'h92;
      4'd6: return 8'h82;
      4'd7: return 8'hF8;
      4'd8: return 8'h80;
      4'd9: return 8'h98;
      default: return 8'h00;
    endcase
  endfunction

  task automatic reset_meter_model();
    min_reg = ssd_pkg::MIN_SPEED_RST;
    rounds_reg = ssd_pkg::DISPLAY_ROUNDS_RST;
    scale_reg = ssd_pkg::SPEED_SCALE_RST;
    win_count = 0;
    sum_acc = 0;
    show_on = 1'b0;
    rounds_shown = 0;
    slot_next = 0;
    shown_bcd = '0;
  endtask

  // Advance the predictor by one request and return the display result
  function automatic ssd_pkg::result_t compute_meter_result(
      input ssd_pkg::opcode_t op, input logic [ssd_pkg::DIST_W-1:0] reading);
    ssd_pkg::result_t  res;
    int unsigned       gap_cm;
    int unsigned       older;
    int unsigned       slot;
    longint unsigned   speed;
    logic [3:0]        digit;
    res = '0;
    if (op == ssd_pkg::OP_SAMPLE) begin
      if (show_on) begin
        res.sample_dropped = 1'b1;
        return res;
      end
      if (win_count >= ssd_pkg::SAMPLES) win_count = 0;
      win_store[win_count] = reading;
      if (win_count >= 2) begin
        older = win_store[win_count - 2];
        gap_cm = (reading > older) ? reading - older : older - reading;
        sum_acc = sum_acc + gap_cm * 5 / 3;
        if (sum_acc > 65535) sum_acc = 65535;
      end
      win_count++;
      if (win_count >= ssd_pkg::SAMPLES) begin
        speed = sum_acc;
        speed = ((speed * scale_reg) >> 16) & 64'hFFFF;
        res.speed_value = speed[15:0];
        res.speed_valid = 1'b1;
        win_count = 0;
        sum_acc = 0;
        if (speed > min_reg && speed <= 999) begin
          shown_bcd = {4'(speed / 100), 4'((speed / 10) % 10), 4'(speed % 10)};
          show_on = 1'b1;
          rounds_shown = 0;
          slot_next = 0;
        end
      end
      return res;
    end
    if (!show_on) return res;
    slot = (slot_next <= 2) ? slot_next : 0;
    digit = 4'(shown_bcd >> ((2 - slot) * 4));
    res.digit_enable = 3'b100 >> slot;
    res.segments = segment_pattern(digit);
    if (slot == 2) begin
      slot_next = 0;
      rounds_shown = (rounds_shown + 1) & 16'hFFFF;
      if (rounds_shown >= rounds_reg || rounds_shown == 0) begin
        show_on = 1'b0;
        rounds_shown = 0;
      end
    end else begin
      slot_next = slot + 1;
    end
    return res;
  endfunction

  // Offer one request, hold it until accepted, then record its expectation
  task automatic send_request(input ssd_pkg::opcode_t op,
                              input logic [ssd_pkg::DIST_W-1:0] reading);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_distance <= reading;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(compute_meter_result(op, reading));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_register(input ssd_pkg::reg_idx_t idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ssd_pkg::REG_MIN_SPEED:      min_reg = value;
      ssd_pkg::REG_DISPLAY_ROUNDS: rounds_reg = value;
      ssd_pkg::REG_SPEED_SCALE:    scale_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [15:0] min_speed, input logic [15:0] rounds,
                                input logic [15:0] scale);
    write_register(ssd_pkg::REG_MIN_SPEED, min_speed);
    write_register(ssd_pkg::REG_DISPLAY_ROUNDS, rounds);
    write_register(ssd_pkg::REG_SPEED_SCALE, scale);
  endtask

  task automatic send_window(input logic [ssd_pkg::DIST_W-1:0] points [ssd_pkg::SAMPLES]);
    for (int i = 0; i < ssd_pkg::SAMPLES; i++) send_request(ssd_pkg::OP_SAMPLE, points[i]);
  endtask

  // Next reading of a noisy linear ramp, or a random one in a wild window; start a new ramp at each window
  function automatic logic [ssd_pkg::DIST_W-1:0] next_distance();
    int pos;
    int cm;
    pos = (win_count >= ssd_pkg::SAMPLES) ? 0 : int'(win_count);
    if (pos == 0) begin
      ramp_base = int'($urandom_range(4095));
      ramp_step = int'($urandom_range(0, 160));
      if ($urandom_range(1)) ramp_step = -ramp_step;
      ramp_wild = ($urandom_range(99) < 10);
    end
    if (ramp_wild) return ssd_pkg::DIST_W'($urandom_range(4095));
    cm = ramp_base + pos * ramp_step + int'($urandom_range(0, 6)) - 3;
    if (cm < 0) cm = 0;
    if (cm > 4095) cm = 4095;
    return ssd_pkg::DIST_W'(cm);
  endfunction

  // Mostly ramp samples while dark, mostly ticks while lit
  task automatic run_traffic(input int count);
    ssd_pkg::opcode_t           op;
    logic [ssd_pkg::DIST_W-1:0] reading;
    bit                         counts;
    int                         done;
    done = 0;
    while (done < count) begin
      if (show_on) begin
        op = ($urandom_range(99) < 90) ? ssd_pkg::OP_TICK : ssd_pkg::OP_SAMPLE;
      end else begin
        op = ($urandom_range(99) < 88) ? ssd_pkg::OP_SAMPLE : ssd_pkg::OP_TICK;
      end
      reading = (op == ssd_pkg::OP_SAMPLE && !show_on) ? next_distance()
                                                       : ssd_pkg::DIST_W'($urandom_range(4095));
      counts = (op == ssd_pkg::OP_SAMPLE) ? !show_on : show_on;
      send_request(op, reading);
      if (counts) done++;
    end
    drain_results();
  endtask

  task automatic test_idle_tick();
    send_request(ssd_pkg::OP_TICK, 12'hFFF);
    send_request(ssd_pkg::OP_TICK, 12'h000);
    drain_results();
  endtask

  // Full-scale swings: speed far above the display range
  task automatic test_window_extremes();
    logic [ssd_pkg::DIST_W-1:0] points [ssd_pkg::SAMPLES];
    for (int i = 0; i < ssd_pkg::SAMPLES; i++) points[i] = ((i / 2) % 2) ? 12'hFFF : 12'h000;
    send_window(points);
    drain_results();
  endtask

  // One lit round, a dropped sample, then the display going dark
  task automatic test_display_cycle();
    logic [ssd_pkg::DIST_W-1:0] points [ssd_pkg::SAMPLES];
    write_settings(16'd10, 16'd1, ssd_pkg::SPEED_SCALE_RST);
    points = '{default: '0};
    points[ssd_pkg::SAMPLES - 1] = 12'd600;
    send_window(points);
    send_request(ssd_pkg::OP_SAMPLE, 12'hABC);
    repeat (4) send_request(ssd_pkg::OP_TICK, 12'h555);
    send_request(ssd_pkg::OP_SAMPLE, 12'h123);
    drain_results();
  endtask

  // Top of the display range, longest rounds cut short, then dead settings
  task automatic test_register_extremes();
    logic [ssd_pkg::DIST_W-1:0] points [ssd_pkg::SAMPLES];
    write_settings(16'd0, 16'hFFFF, 16'hFFFF);
    points = '{default: '0};
    points[ssd_pkg::SAMPLES - 1] = 12'd600;
    send_window(points);
    repeat (4) send_request(ssd_pkg::OP_TICK, 12'h2AA);
    drain_results();
    write_register(ssd_pkg::REG_DISPLAY_ROUNDS, 16'd1);
    repeat (3) send_request(ssd_pkg::OP_TICK, 12'hD55);
    drain_results();
    // Speed just past the range, then equal to the threshold
    points[ssd_pkg::SAMPLES - 1] = 12'd601;
    send_window(points);
    drain_results();
    write_register(ssd_pkg::REG_MIN_SPEED, 16'd999);
    points[ssd_pkg::SAMPLES - 1] = 12'd600;
    send_window(points);
    drain_results();
    write_settings(16'hFFFF, 16'd0, 16'd0);
    send_window(points);
    drain_results();
  endtask

  // Hold the receiver off while requests keep coming, then pause the sender
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_settings(16'd10, 16'd2, ssd_pkg::SPEED_SCALE_RST);
    hold_left = 60;
    run_traffic(40);
    hold_left = 40;
    run_traffic(20);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [15:0] min_speed,
                                     input logic [15:0] rounds,
                                     input logic [15:0] scale, input int count);
    write_settings(min_speed, rounds, scale);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    run_traffic(count / 2);
    // Quiet stretch: no gaps, no stalls
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_traffic(count / 8);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    run_traffic(count - count / 2 - count / 8);
  endtask

  // Receiver ready: long hold-offs first, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.digit_enable = out_digit_enable;
      seen_result.segments = out_segments;
      seen_result.speed_value = out_speed_value;
      seen_result.speed_valid = out_speed_valid;
      seen_result.sample_dropped = out_sample_dropped;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result: %p", seen_result);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result !== want_result) begin
          if (mismatch_count < 10) begin
            $display("mismatch: digit_enable %0d/%0d segments %h/%h speed %0d/%0d",
                     want_result.digit_enable, seen_result.digit_enable,
                     want_result.segments, seen_result.segments,
                     want_result.speed_value, seen_result.speed_value);
            $display("  speed_valid %0d/%0d sample_dropped %0d/%0d (expected/actual)",
                     want_result.speed_valid, seen_result.speed_valid,
                     want_result.sample_dropped, seen_result.sample_dropped);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    reset_meter_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_tick();
    test_window_extremes();
    test_display_cycle();
    test_register_extremes();
    test_backpressure();
    test_random_traffic(0, 0, 16'd10, 16'd2, 16'd15943, 250);
    test_random_traffic(64, 0, 16'd0, 16'd1, 16'hFFFF, 250);
    test_random_traffic(0, 64, 16'd300, 16'd3, 16'd40000, 250);
    test_random_traffic(23, 23, 16'd5, 16'd0, 16'd8000, 250);
    // Let the longest window closure settle before the verdict
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[sonar_speed_seven_segment_display] OK");
    end else begin
      $display("[sonar_speed_seven_segment_display] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[sonar_speed_seven_segment_display] ERROR");
    $finish;
  end

endmodule
